// ===== hdl/tdd_pkg.sv =====
// tdd_pkg: shared types and constants for the tank draw-off detector
// holds the detector state struct, command and register codes
// no dependencies
`timescale 1ns / 1ps

package tdd_pkg;

  // command codes carried in func
  localparam logic FuncTick   = 1'b0;
  localparam logic FuncNewDay = 1'b1;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegDropThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWindowSeconds = 2'd1;

  // window in ms fits 26 bits (65535 * 1000), timeout 27 bits
  localparam int unsigned WinMsW     = 26;
  localparam int unsigned TimeoutMsW = WinMsW + 1;
  localparam logic [9:0]  MsPerSec   = 10'd1000;

  // reset values of the registers
  localparam logic [14:0]       DropThresholdRst = 15'd200;
  localparam logic [WinMsW-1:0] WinMsRst         = 26'd900000;

  // rise above the minimum that ends a draw, hundredths of kelvin
  localparam logic signed [16:0] RiseHyst = 17'sd10;

  // detector state carried from item to item
  typedef struct packed {
    logic               have_ref;
    logic signed [15:0] ref_temp;
    logic [31:0]        ref_time;
    logic               in_draw;
    logic signed [15:0] start_temp;
    logic signed [15:0] lowest_temp;
    logic [31:0]        begin_time;
    logic [15:0]        latest_drop;
    logic [31:0]        total_drop;
    logic [15:0]        closed_count;
  } tdd_state_t;

endpackage

// ===== hdl/tank_draw_off_detector_core.sv =====
// tank_draw_off_detector_core: top level of the hot-water draw-off detector
// input register, tdd_step next-state logic, state and result registers
// depends on tdd_pkg and tdd_step
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o) carries one tick word: func,
//   burner_on, sample_valid, tank_temp and time_ms. func = new day clears
//   the daily sum and count only. Every word yields exactly one result word
//   on the output channel (out_valid_o / out_ready_i): draw_active,
//   draw_closed, last_drop, drop_sum and draw_count after that word.
//   Configuration port (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes drop_threshold (index 0) and window_seconds (index 1); it is
//   always ready. Write it only while no word is in flight.
//   A word moves from the input register to the result register once that
//   is free. Throughput: one word per cycle while the receiver keeps up;
//   the state update is a single pass of compares and one 32-bit saturating
//   add between the input register and the state/result registers.
//   Reset clears all state, empties both registers and loads threshold 200
//   and window 900 s. When the receiver stalls, the result holds, one more
//   word is taken into the input register, and then in_ready_o drops.
module tank_draw_off_detector_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tdd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic                        burner_on_i,
  input  logic                        sample_valid_i,
  input  logic signed [15:0]          tank_temp_i,
  input  logic [31:0]                 time_ms_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        draw_active_o,
  output logic                        draw_closed_o,
  output logic [15:0]                 last_drop_o,
  output logic [31:0]                 drop_sum_o,
  output logic [15:0]                 draw_count_o
);
  import tdd_pkg::*;

  logic               in_vld_q;
  logic               func_q;
  logic               burner_q;
  logic               sample_vld_q;
  logic signed [15:0] temp_q;
  logic [31:0]        time_q;

  logic [14:0]        thr_q;
  logic [WinMsW-1:0]  win_ms_q;
  logic [WinMsW-1:0]  win_ms_wr;

  tdd_state_t         state_q;
  tdd_state_t         state_d;
  logic               closed_d;

  logic               out_vld_q;
  logic               active_q;
  logic               closed_q;
  logic [15:0]        last_drop_q;
  logic [31:0]        drop_sum_q;
  logic [15:0]        count_q;

  logic               advance;

  // configuration registers, window kept in milliseconds
  assign cfg_ready_o = 1'b1;
  assign win_ms_wr   = WinMsW'(cfg_data_i) * WinMsW'(MsPerSec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= DropThresholdRst;
      win_ms_q <= WinMsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegDropThreshold: thr_q    <= cfg_data_i[14:0];
        RegWindowSeconds: win_ms_q <= win_ms_wr;
        default: ;
      endcase
    end
  end

  // handshake: a word moves on when the result register is free
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q       <= func_i;
      burner_q     <= burner_on_i;
      sample_vld_q <= sample_valid_i;
      temp_q       <= tank_temp_i;
      time_q       <= time_ms_i;
    end
  end

  // next-state logic
  tdd_step u_step (
    .state_i          (state_q),
    .func_i           (func_q),
    .burner_on_i      (burner_q),
    .sample_valid_i   (sample_vld_q),
    .tank_temp_i      (temp_q),
    .time_ms_i        (time_q),
    .drop_threshold_i (thr_q),
    .win_ms_i         (win_ms_q),
    .state_o          (state_d),
    .draw_closed_o    (closed_d)
  );

  // detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      active_q    <= state_d.in_draw;
      closed_q    <= closed_d;
      last_drop_q <= state_d.latest_drop;
      drop_sum_q  <= state_d.total_drop;
      count_q     <= state_d.closed_count;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign draw_active_o = active_q;
  assign draw_closed_o = closed_q;
  assign last_drop_o   = last_drop_q;
  assign drop_sum_o    = drop_sum_q;
  assign draw_count_o  = count_q;

  // a close never leaves a draw running
  a_close_ends_draw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && closed_q |-> !active_q)
    else $error("draw still active on a closing result");

  // a new-day word yields a cleared sum and count
  a_new_day_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (func_q == FuncNewDay) |=> out_vld_q && (drop_sum_q == 32'd0)
      && (count_q == 16'd0) && !closed_q)
    else $error("new day did not clear sum and count");

  // an empty result register never blocks the input side
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  // the detector state only changes when a word moves on
  a_state_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a word");

endmodule

// ===== hdl/tdd_step.sv =====
// tdd_step: next-state logic of the draw-off detector for one word
// pure combinational; computes the state after the word and the close flag
// depends on tdd_pkg
`timescale 1ns / 1ps

module tdd_step (
  input  tdd_pkg::tdd_state_t        state_i,
  input  logic                       func_i,
  input  logic                       burner_on_i,
  input  logic                       sample_valid_i,
  input  logic signed [15:0]         tank_temp_i,
  input  logic [31:0]                time_ms_i,
  input  logic [14:0]                drop_threshold_i,
  input  logic [tdd_pkg::WinMsW-1:0] win_ms_i,
  output tdd_pkg::tdd_state_t        state_o,
  output logic                       draw_closed_o
);
  import tdd_pkg::*;

  logic [TimeoutMsW-1:0] timeout_ms;
  logic [31:0]           since_ref;
  logic [31:0]           since_begin;
  logic                  good_tick;
  logic signed [15:0]    lowest_new;
  logic signed [15:0]    lowest_cl;
  logic signed [16:0]    drop_raw;
  logic [15:0]           drop_val;
  logic [32:0]           sum_raw;
  logic [31:0]           sum_sat;
  logic [15:0]           count_sat;
  logic                  ref_upd;
  logic signed [15:0]    ref_new;
  logic signed [16:0]    fall;
  logic                  draw_start;
  logic                  rise_end;
  logic                  time_end;

  // elapsed times, modulo 2^32
  assign timeout_ms  = {win_ms_i, 1'b0};
  assign since_ref   = time_ms_i - state_i.ref_time;
  assign since_begin = time_ms_i - state_i.begin_time;
  assign good_tick   = sample_valid_i && !burner_on_i;

  // running minimum during a draw
  assign lowest_new = (tank_temp_i < state_i.lowest_temp) ? tank_temp_i : state_i.lowest_temp;

  // close bookkeeping: a forced close uses the stored minimum
  assign lowest_cl = good_tick ? lowest_new : state_i.lowest_temp;
  assign drop_raw  = 17'(state_i.start_temp) - 17'(lowest_cl);
  assign drop_val  = drop_raw[16] ? 16'd0 : drop_raw[15:0];
  assign sum_raw   = {1'b0, state_i.total_drop} + {17'd0, drop_val};
  assign sum_sat   = sum_raw[32] ? 32'hFFFF_FFFF : sum_raw[31:0];
  assign count_sat = (&state_i.closed_count) ? state_i.closed_count
                                             : state_i.closed_count + 16'd1;

  // idle path: reference tracking and draw start
  assign ref_upd    = (tank_temp_i > state_i.ref_temp) ||
                      (since_ref >= {{(32-WinMsW){1'b0}}, win_ms_i});
  assign ref_new    = ref_upd ? tank_temp_i : state_i.ref_temp;
  assign fall       = 17'(ref_new) - 17'(tank_temp_i);
  assign draw_start = fall >= $signed({2'b00, drop_threshold_i});

  // draw path: end by rise over the minimum or by timeout
  assign rise_end = 17'(tank_temp_i) > (17'(lowest_new) + RiseHyst);
  assign time_end = since_begin >= {{(32-TimeoutMsW){1'b0}}, timeout_ms};

  // state update
  always_comb begin
    state_o       = state_i;
    draw_closed_o = 1'b0;
    if (func_i == FuncNewDay) begin
      state_o.total_drop   = 32'd0;
      state_o.closed_count = 16'd0;
    end else if (!good_tick) begin
      if (state_i.in_draw) begin
        draw_closed_o        = 1'b1;
        state_o.in_draw      = 1'b0;
        state_o.latest_drop  = drop_val;
        state_o.total_drop   = sum_sat;
        state_o.closed_count = count_sat;
      end
      state_o.have_ref = 1'b0;
    end else if (!state_i.have_ref) begin
      state_o.have_ref = 1'b1;
      state_o.ref_temp = tank_temp_i;
      state_o.ref_time = time_ms_i;
    end else if (!state_i.in_draw) begin
      if (ref_upd) begin
        state_o.ref_temp = tank_temp_i;
        state_o.ref_time = time_ms_i;
      end
      if (draw_start) begin
        state_o.in_draw     = 1'b1;
        state_o.start_temp  = ref_new;
        state_o.lowest_temp = tank_temp_i;
        state_o.begin_time  = time_ms_i;
      end
    end else begin
      state_o.lowest_temp = lowest_new;
      if (rise_end || time_end) begin
        draw_closed_o        = 1'b1;
        state_o.in_draw      = 1'b0;
        state_o.latest_drop  = drop_val;
        state_o.total_drop   = sum_sat;
        state_o.closed_count = count_sat;
        state_o.ref_temp     = tank_temp_i;
        state_o.ref_time     = time_ms_i;
      end
    end
  end

endmodule

// ===== tb/sv/tb_tank_draw_off_detector_core.sv =====
// tb_tank_draw_off_detector_core: self-checking testbench for the draw-off detector
// predicts every result word in-line and checks it against the result channel
// depends on tdd_pkg and tank_draw_off_detector_core
`timescale 1ns / 1ps

module tb_tank_draw_off_detector_core;
  import tdd_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned SatPairs   = 4;
  localparam int unsigned SweepRuns  = 12;
  localparam int unsigned SweepTicks = 118;

  // one result word as the detector reports it
  typedef struct packed {
    logic        draw_active;
    logic        draw_closed;
    logic [15:0] last_drop;
    logic [31:0] drop_sum;
    logic [15:0] draw_count;
  } draw_status_t;

  // dut ports, all inputs known from time zero
  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_valid_i    = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i    = RegDropThreshold;
  logic [15:0]              cfg_data_i     = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic                     func_i         = FuncTick;
  logic                     burner_on_i    = 1'b0;
  logic                     sample_valid_i = 1'b0;
  logic signed [15:0]       tank_temp_i    = '0;
  logic [31:0]              time_ms_i      = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic                     draw_active_o;
  logic                     draw_closed_o;
  logic [15:0]              last_drop_o;
  logic [31:0]              drop_sum_o;
  logic [15:0]              draw_count_o;

  // detector state as predicted, starts at the reset values
  logic               ref_held         = 1'b0;
  logic signed [15:0] ref_temp_q       = '0;
  logic [31:0]        ref_time_q       = '0;
  logic               drawing          = 1'b0;
  logic signed [15:0] draw_start_temp  = '0;
  logic signed [15:0] draw_min_temp    = '0;
  logic [31:0]        draw_start_time  = '0;
  logic [15:0]        recent_drop      = '0;
  logic [31:0]        daily_drop_sum   = '0;
  logic [15:0]        daily_draw_count = '0;
  logic [14:0]        threshold_cfg    = DropThresholdRst;
  logic [15:0]        window_cfg       = 16'd900;

  draw_status_t expected_status[$];

  // run bookkeeping
  int unsigned cycle_count     = 0;
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned closes_seen     = 0;
  int unsigned ticks_sent      = 0;
  int unsigned new_day_words   = 0;
  int unsigned settings_used   = 0;
  logic        sum_saturated   = 1'b0;
  int unsigned burst_left      = 0;
  logic        rx_full_speed   = 1'b0;
  logic [1:0]  stall_mode      = 2'd0;
  logic [31:0] clock_ms        = 32'h1234_5678;
  int          walk_temp       = 5000;

  tank_draw_off_detector_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .burner_on_i    (burner_on_i),
    .sample_valid_i (sample_valid_i),
    .tank_temp_i    (tank_temp_i),
    .time_ms_i      (time_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .draw_active_o  (draw_active_o),
    .draw_closed_o  (draw_closed_o),
    .last_drop_o    (last_drop_o),
    .drop_sum_o     (drop_sum_o),
    .draw_count_o   (draw_count_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // cycle counter and run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_status.size());
      $display("FAIL tank_draw_off_detector_core");
      $finish;
    end
  end

  // receiver stall pattern, mode picked at random whenever the low byte of the cycle counter is zero
  always @(posedge clk_i) begin
    if (rx_full_speed) begin
      out_ready_i <= 1'b1;
    end else begin
      case (stall_mode)
        2'd0:    out_ready_i <= 1'b1;
        2'd1:    out_ready_i <= ($urandom_range(0, 1) == 0);
        2'd2:    out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (cycle_count[2:0] != 3'd0);
      endcase
    end
    if (cycle_count[7:0] == 8'd0) stall_mode <= 2'($urandom_range(0, 3));
  end

  // close the running draw and book its drop
  function automatic logic finish_draw();
    int span;
    if (!drawing) return 1'b0;
    span = int'(draw_start_temp) - int'(draw_min_temp);
    if (span < 0) span = 0;
    if (span > 65535) span = 65535;
    drawing = 1'b0;
    recent_drop = span[15:0];
    if (daily_drop_sum > 32'hFFFF_FFFF - 32'(span)) daily_drop_sum = '1;
    else daily_drop_sum = daily_drop_sum + 32'(span);
    if (daily_draw_count != 16'hFFFF) daily_draw_count = daily_draw_count + 16'd1;
    return 1'b1;
  endfunction

  // apply one tick word to the predicted state and return the result word
  function automatic draw_status_t advance_detector(input logic fn, input logic burner,
                                                    input logic good,
                                                    input logic signed [15:0] temp,
                                                    input logic [31:0] now_ms);
    logic [31:0]  win_ms;
    logic [31:0]  timeout_ms;
    logic         closed;
    draw_status_t status;
    win_ms     = 32'(window_cfg) * 32'd1000;
    timeout_ms = 32'(window_cfg) * 32'd2000;
    closed     = 1'b0;
    if (fn == FuncNewDay) begin
      daily_drop_sum   = '0;
      daily_draw_count = '0;
    end else if (!good || burner) begin
      closed   = finish_draw();
      ref_held = 1'b0;
    end else if (!ref_held) begin
      ref_held   = 1'b1;
      ref_temp_q = temp;
      ref_time_q = now_ms;
    end else if (!drawing) begin
      // reference follows rises and renews when the window runs out
      if (temp > ref_temp_q || (now_ms - ref_time_q) >= win_ms) begin
        ref_temp_q = temp;
        ref_time_q = now_ms;
      end
      if (int'(ref_temp_q) - int'(temp) >= int'(threshold_cfg)) begin
        drawing         = 1'b1;
        draw_start_temp = ref_temp_q;
        draw_min_temp   = temp;
        draw_start_time = now_ms;
      end
    end else begin
      // track the minimum, close on rise past hysteresis or on timeout
      if (temp < draw_min_temp) draw_min_temp = temp;
      if (int'(temp) > int'(draw_min_temp) + int'(RiseHyst) ||
          (now_ms - draw_start_time) >= timeout_ms) begin
        closed     = finish_draw();
        ref_temp_q = temp;
        ref_time_q = now_ms;
      end
    end
    status.draw_active = drawing;
    status.draw_closed = closed;
    status.last_drop   = recent_drop;
    status.drop_sum    = daily_drop_sum;
    status.draw_count  = daily_draw_count;
    return status;
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_results
    draw_status_t got;
    draw_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{draw_active_o, draw_closed_o, last_drop_o, drop_sum_o, draw_count_o};
      results_checked++;
      if (got.draw_closed) closes_seen++;
      if (got.drop_sum == 32'hFFFF_FFFF) sum_saturated = 1'b1;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("result word %0d with nothing expected: active=%0b closed=%0b",
                   results_checked, got.draw_active, got.draw_closed);
      end else begin
        want = expected_status.pop_front();
        if (got.draw_active !== want.draw_active || got.draw_closed !== want.draw_closed ||
            got.last_drop !== want.last_drop || got.drop_sum !== want.drop_sum ||
            got.draw_count !== want.draw_count) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("mismatch at result word %0d:", results_checked);
            $display("  expected active=%0b closed=%0b last=%0d sum=%0d count=%0d",
                     want.draw_active, want.draw_closed, want.last_drop, want.drop_sum,
                     want.draw_count);
            $display("  actual   active=%0b closed=%0b last=%0d sum=%0d count=%0d",
                     got.draw_active, got.draw_closed, got.last_drop, got.drop_sum,
                     got.draw_count);
          end
        end
      end
    end
  end

  // present one tick word and predict its result once it is taken
  task automatic send_tick(input logic fn, input logic burner, input logic good,
                           input logic signed [15:0] temp, input logic [31:0] now_ms);
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    burner_on_i    <= burner;
    sample_valid_i <= good;
    tank_temp_i    <= temp;
    time_ms_i      <= now_ms;
    do @(posedge clk_i); while (!in_ready_o);
    expected_status.push_back(advance_detector(fn, burner, good, temp, now_ms));
    ticks_sent++;
    if (fn == FuncNewDay) new_day_words++;
  endtask

  // send with bursts and random gaps between them
  task automatic offer_tick(input logic fn, input logic burner, input logic good,
                            input logic signed [15:0] temp, input logic [31:0] now_ms);
    int unsigned gap;
    send_tick(fn, burner, good, temp, now_ms);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 16);
    end
  endtask

  // wait until every result word has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegDropThreshold) threshold_cfg = data[14:0];
    else window_cfg = data;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [14:0] thr, input logic [15:0] win);
    settle();
    write_reg(RegDropThreshold, {1'b0, thr});
    write_reg(RegWindowSeconds, win);
    settings_used++;
  endtask

  // reference, rise, threshold edge, hysteresis edge, new day mid draw,
  // burner and invalid-sample closes, burner with nothing running
  task automatic test_draw_lifecycle();
    offer_tick(FuncTick,   1'b0, 1'b1, 16'sd5000, 32'd1000);
    offer_tick(FuncTick,   1'b0, 1'b1, 16'sd5100, 32'd2000);
    offer_tick(FuncTick,   1'b0, 1'b1, 16'sd4950, 32'd3000);
    offer_tick(FuncTick,   1'b0, 1'b1, 16'sd4900, 32'd4000);
    offer_tick(FuncTick,   1'b0, 1'b1, 16'sd4800, 32'd5000);
    offer_tick(FuncNewDay, 1'b1, 1'b0, 16'sd0,    32'd6000);
    offer_tick(FuncTick,   1'b0, 1'b1, 16'sd4810, 32'd7000);
    offer_tick(FuncTick,   1'b0, 1'b1, 16'sd4811, 32'd8000);
    offer_tick(FuncNewDay, 1'b0, 1'b1, 16'sd4811, 32'd8500);
    offer_tick(FuncTick,   1'b0, 1'b1, 16'sd4500, 32'd9000);
    offer_tick(FuncTick,   1'b1, 1'b1, 16'sd4400, 32'd10000);
    offer_tick(FuncTick,   1'b0, 1'b1, 16'sd4500, 32'd11000);
    offer_tick(FuncTick,   1'b0, 1'b1, 16'sd4200, 32'd12000);
    offer_tick(FuncTick,   1'b0, 1'b0, 16'sd0,    32'd13000);
    offer_tick(FuncTick,   1'b1, 1'b0, 16'h7FFF,  32'd14000);
  endtask

  // full-scale drop, timeout across the 32-bit wrap, window renewal
  task automatic test_extremes_and_wrap();
    logic [31:0] t0;
    logic [31:0] t1;
    t0 = 32'hFFFF_0000;
    offer_tick(FuncTick, 1'b0, 1'b1, 16'h7FFF, t0);
    offer_tick(FuncTick, 1'b0, 1'b1, 16'h8000, t0 + 32'd1);
    offer_tick(FuncTick, 1'b0, 1'b1, 16'h8000, t0 + 32'd1_800_000);
    offer_tick(FuncTick, 1'b0, 1'b1, 16'h8000, t0 + 32'd1_800_001);
    t1 = t0 + 32'd1_801_001;
    offer_tick(FuncTick, 1'b0, 1'b1, -16'sd32700, t1);
    offer_tick(FuncTick, 1'b0, 1'b1, -16'sd32760, t1 + 32'd900_000);
  endtask

  // reference renewed exactly at the window, then a draw closed by timeout
  task automatic test_window_refresh();
    logic [31:0] t0;
    t0 = 32'h7000_0000;
    offer_tick(FuncTick, 1'b0, 1'b1, 16'sd3000, t0);
    offer_tick(FuncTick, 1'b0, 1'b1, 16'sd2850, t0 + 32'd899_999);
    offer_tick(FuncTick, 1'b0, 1'b1, 16'sd2900, t0 + 32'd900_000);
    offer_tick(FuncTick, 1'b0, 1'b1, 16'sd2700, t0 + 32'd900_001);
    offer_tick(FuncTick, 1'b0, 1'b1, 16'sd2695, t0 + 32'd2_700_001);
  endtask

  // random temperature walk with drops, rises, burner, bad samples and new days
  task automatic run_random_ticks(input int unsigned count);
    int unsigned        pick;
    int unsigned        span_ms;
    logic signed [15:0] noise_temp;
    for (int unsigned n = 0; n < count; n++) begin
      pick       = $urandom_range(0, 99);
      span_ms    = 32'(window_cfg) * 500 + 50;
      noise_temp = 16'($urandom());
      if ($urandom_range(0, 24) == 0) clock_ms = clock_ms + $urandom();
      else clock_ms = clock_ms + $urandom_range(0, span_ms);
      if (pick < 3) begin
        offer_tick(FuncNewDay, 1'($urandom()), 1'($urandom()), noise_temp, clock_ms);
      end else if (pick < 6) begin
        offer_tick(FuncTick, 1'b1, 1'($urandom()), noise_temp, clock_ms);
      end else if (pick < 9) begin
        offer_tick(FuncTick, 1'b0, 1'b0, noise_temp, clock_ms);
      end else begin
        if (pick < 11) walk_temp = int'(noise_temp);
        else if (pick < 27) walk_temp -= int'(threshold_cfg) + int'($urandom_range(0, 200));
        else if (pick < 40) walk_temp += int'($urandom_range(0, 40));
        else walk_temp += int'($urandom_range(0, 24)) - 12;
        if (walk_temp > 32767) walk_temp = 32767;
        if (walk_temp < -32768) walk_temp = -32768;
        offer_tick(FuncTick, 1'b0, 1'b1, 16'(walk_temp), clock_ms);
      end
    end
  endtask

  // random traffic under extreme and random register settings
  task automatic test_register_sweep();
    logic [14:0] thr;
    logic [15:0] win;
    int unsigned pick;
    for (int unsigned run = 0; run < SweepRuns; run++) begin
      pick = $urandom_range(0, 99);
      case (run)
        0: begin thr = 15'd0;     win = 16'd0;     end
        1: begin thr = 15'h7FFF;  win = 16'hFFFF;  end
        2: begin thr = 15'd0;     win = 16'd1;     end
        3: begin thr = 15'h7FFF;  win = 16'd0;     end
        default: begin
          if (pick < 25) thr = 15'($urandom_range(0, 50));
          else if (pick < 75) thr = 15'($urandom_range(50, 500));
          else if (pick < 90) thr = 15'($urandom_range(500, 5000));
          else thr = 15'($urandom());
          pick = $urandom_range(0, 99);
          if (pick < 60) win = 16'($urandom_range(1, 5));
          else if (pick < 70) win = 16'd0;
          else if (pick < 85) win = 16'($urandom_range(300, 1000));
          else win = 16'($urandom());
        end
      endcase
      set_config(thr, win);
      run_random_ticks(SweepTicks);
    end
  endtask

  // back-to-back full-scale draws with the receiver always ready, then new day
  task automatic test_full_scale_draws();
    set_config(15'd100, 16'hFFFF);
    rx_full_speed <= 1'b1;
    clock_ms = 32'hFFFF_F000;
    send_tick(FuncTick, 1'b1, 1'b1, 16'sd0, clock_ms);
    send_tick(FuncNewDay, 1'b0, 1'b1, 16'sd0, clock_ms);
    send_tick(FuncTick, 1'b0, 1'b1, 16'h7FFF, clock_ms);
    for (int unsigned n = 0; n < SatPairs; n++) begin
      clock_ms = clock_ms + 32'd1;
      send_tick(FuncTick, 1'b0, 1'b1, 16'h8000, clock_ms);
      clock_ms = clock_ms + 32'd1;
      send_tick(FuncTick, 1'b0, 1'b1, 16'h7FFF, clock_ms);
    end
    send_tick(FuncNewDay, 1'b0, 1'b0, 16'h8000, clock_ms);
    send_tick(FuncTick, 1'b0, 1'b1, 16'h8000, clock_ms + 32'd1);
    send_tick(FuncTick, 1'b0, 1'b1, 16'h7FFF, clock_ms + 32'd2);
    settle();
    rx_full_speed <= 1'b0;
  endtask

  // test sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_draw_lifecycle();
    test_extremes_and_wrap();
    test_window_refresh();
    test_register_sweep();
    test_full_scale_draws();

    settle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d tick words (%0d new-day) over %0d register settings",
             ticks_sent, new_day_words, settings_used);
    $display("checked %0d result words, %0d draw closes, sum saturation %0s, %0d mismatches",
             results_checked, closes_seen, sum_saturated ? "reached" : "not reached",
             mismatches);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("PASS tank_draw_off_detector_core");
    end else begin
      $display("FAIL tank_draw_off_detector_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tdd_pkg.sv
hdl/tdd_step.sv
hdl/tank_draw_off_detector_core.sv
tb/sv/tb_tank_draw_off_detector_core.sv
